// ===== design/bbltd_pkg.sv =====
// Shared codes and defaults for the byte-budget LRU tile directory.
package bbltd_pkg;
    localparam int ENTRIES_DEF     = 256;
    localparam int KEY_BITS_DEF    = 64;
    localparam int SERIAL_BITS_DEF = 48;
    localparam int BUDGET_W        = 40;
    localparam int IN_DATA_W       = 136;
    localparam int OUT_DATA_W      = 216;

    localparam logic [2:0] OP_LOOKUP = 3'd0;
    localparam logic [2:0] OP_STORE  = 3'd1;
    localparam logic [2:0] OP_INVAL  = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_TRIM   = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
endpackage

// ===== design/byte_budget_lru_tile_directory_unit.sv =====
// Top level: byte-budget LRU tile directory with a scanned slot table.
//
// channel   | dir | tdata fields (low bit up)                        | tuser
// s_axis    | in  | operation, entry_key, source_tag, size_bytes     | entry_kind
// m_axis    | out | status, slot, evicted_now, removed_now,          | -
//           |     | bytes_in_use, source_entries, transformed_entries,|
//           |     | kind_hits, kind_misses, total_evictions,         |
//           |     | total_invalidations                              |
// cfg       | in  | cfg_wr_data = ram_budget                         | -
//
// One item at a time. A lookup, invalidate or store scan reads one table slot per
// cycle from the slot memory (one read, one write port). Each eviction adds one
// more LRU scan over the table, plus one budget compare when it comes from
// trimming. Clear, trim with no eviction and unknown operations skip the scan.
// Reset clears the valid bits at once; no clearing pass.
// A stalled result holds the block until it is taken.
module byte_budget_lru_tile_directory_unit #(
    parameter int ENTRIES     = bbltd_pkg::ENTRIES_DEF,
    parameter int KEY_BITS    = bbltd_pkg::KEY_BITS_DEF,
    parameter int SERIAL_BITS = bbltd_pkg::SERIAL_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // operation[2:0], entry_key[66:3], source_tag[98:67], size_bytes[130:99]
    input  logic [bbltd_pkg::IN_DATA_W-1:0] s_tdata,
    // entry_kind[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], slot[9:2], evicted_now[18:10], removed_now[27:19],
    // bytes_in_use[67:28], source_entries[76:68], transformed_entries[85:77],
    // kind_hits[117:86], kind_misses[149:118], total_evictions[181:150],
    // total_invalidations[213:182]
    output logic [bbltd_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [bbltd_pkg::BUDGET_W-1:0]  cfg_wr_data
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int BW = IW + 32;
    localparam int WW = BW + bbltd_pkg::BUDGET_W;
    localparam logic [SERIAL_BITS-1:0] SERIAL_MAX = '1;

    typedef struct packed {
        logic [KEY_BITS-1:0]    key;
        logic                   kind;
        logic [31:0]            src;
        logic [31:0]            size;
        logic [SERIAL_BITS-1:0] lu;
    } rec_t;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LRU, S_WRITE, S_FIT, S_DONE, S_OUT} state_t;

    rec_t mem [ENTRIES];
    rec_t rd_reg;
    logic mem_we;
    logic [IW-1:0] mem_waddr;
    rec_t mem_wdata;
    logic [IW-1:0] rd_addr;

    state_t state_reg;
    logic [bbltd_pkg::BUDGET_W-1:0] budget_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [2:0] op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic kind_reg;
    logic [31:0] src_reg, size_reg;
    logic [SERIAL_BITS-1:0] serial_reg, serial_next;
    logic [BW-1:0] bytes_reg;
    logic [CW-1:0] kcnt_reg [2];
    logic [31:0] hit_reg [2];
    logic [31:0] miss_reg [2];
    logic [31:0] evc_reg, invc_reg;
    logic [1:0] status_reg;
    logic [IW-1:0] slot_reg;
    logic [8:0] evicted_reg, removed_reg;
    logic [IW:0] cnt_reg;
    logic pv_reg;
    logic [IW-1:0] pi_reg;
    logic found_reg;
    logic [IW-1:0] found_idx_reg;
    rec_t found_rec_reg;
    logic free_reg;
    logic [IW-1:0] free_idx_reg;
    logic have_reg;
    logic [IW-1:0] best_idx_reg;
    rec_t best_reg;
    logic store_full_reg;
    logic m_tvalid_reg;
    logic [bbltd_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    logic issuing, pvalid, kmatch, better;
    logic [WW-1:0] bytes_w, budget_w;
    logic [BW-1:0] rd_sub, best_sub;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign issuing  = (cnt_reg < (IW + 1)'(ENTRIES));
    assign rd_addr  = cnt_reg[IW-1:0];
    assign pvalid   = pv_reg && valid_reg[pi_reg];
    assign kmatch   = (rd_reg.key == key_reg);
    assign better   = !have_reg || (rd_reg.lu < best_reg.lu)
                      || ((rd_reg.lu == best_reg.lu) && (rd_reg.key < best_reg.key));
    assign bytes_w  = WW'(bytes_reg);
    assign budget_w = WW'(budget_reg);
    assign rd_sub   = (bytes_reg >= BW'(rd_reg.size)) ? bytes_reg - BW'(rd_reg.size) : '0;
    assign best_sub = (bytes_reg >= BW'(best_reg.size)) ? bytes_reg - BW'(best_reg.size) : '0;
    assign serial_next = (serial_reg < SERIAL_MAX) ? serial_reg + 1'b1 : serial_reg;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = free_idx_reg;
        mem_wdata = '{key: key_reg, kind: kind_reg, src: src_reg, size: size_reg,
                      lu: serial_next};
        if (state_reg == S_WRITE) begin
            if (op_reg == bbltd_pkg::OP_LOOKUP) begin
                mem_we    = 1'b1;
                mem_waddr = found_idx_reg;
                mem_wdata = found_rec_reg;
                mem_wdata.lu = serial_next;
            end else begin
                mem_we = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            budget_reg   <= '0;
            valid_reg    <= '0;
            serial_reg   <= '0;
            bytes_reg    <= '0;
            kcnt_reg[0]  <= '0;
            kcnt_reg[1]  <= '0;
            hit_reg[0]   <= '0;
            hit_reg[1]   <= '0;
            miss_reg[0]  <= '0;
            miss_reg[1]  <= '0;
            evc_reg      <= '0;
            invc_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            pv_reg       <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                budget_reg <= cfg_wr_data;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg      <= s_tdata[2:0];
                        key_reg     <= s_tdata[3 +: KEY_BITS];
                        src_reg     <= s_tdata[98:67];
                        size_reg    <= s_tdata[130:99];
                        kind_reg    <= s_tuser;
                        status_reg  <= bbltd_pkg::ST_OK;
                        slot_reg    <= '0;
                        evicted_reg <= '0;
                        removed_reg <= '0;
                        found_reg   <= 1'b0;
                        free_reg    <= 1'b0;
                        have_reg    <= 1'b0;
                        store_full_reg <= 1'b0;
                        cnt_reg     <= '0;
                        pv_reg      <= 1'b0;
                        case (s_tdata[2:0])
                            bbltd_pkg::OP_LOOKUP, bbltd_pkg::OP_INVAL: begin
                                state_reg <= S_SCAN;
                            end
                            bbltd_pkg::OP_STORE: begin
                                if (budget_reg == '0 || s_tdata[130:99] == 32'd0
                                    || 40'(s_tdata[130:99]) > budget_reg) begin
                                    status_reg <= bbltd_pkg::ST_REJECT;
                                    state_reg  <= S_DONE;
                                end else begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            bbltd_pkg::OP_CLEAR: begin
                                valid_reg   <= '0;
                                bytes_reg   <= '0;
                                kcnt_reg[0] <= '0;
                                kcnt_reg[1] <= '0;
                                hit_reg[0]  <= '0;
                                hit_reg[1]  <= '0;
                                miss_reg[0] <= '0;
                                miss_reg[1] <= '0;
                                evc_reg     <= '0;
                                invc_reg    <= '0;
                                state_reg   <= S_DONE;
                            end
                            bbltd_pkg::OP_TRIM: begin
                                state_reg <= S_FIT;
                            end
                            default: begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    cnt_reg <= issuing ? cnt_reg + 1'b1 : cnt_reg;
                    pv_reg  <= issuing;
                    pi_reg  <= cnt_reg[IW-1:0];
                    if (pv_reg) begin
                        case (op_reg)
                            bbltd_pkg::OP_LOOKUP: begin
                                if (pvalid && kmatch && !found_reg) begin
                                    found_reg     <= 1'b1;
                                    found_idx_reg <= pi_reg;
                                    found_rec_reg <= rd_reg;
                                end
                            end
                            bbltd_pkg::OP_STORE: begin
                                if (pvalid && kmatch) begin
                                    valid_reg[pi_reg]     <= 1'b0;
                                    bytes_reg             <= rd_sub;
                                    kcnt_reg[rd_reg.kind] <= kcnt_reg[rd_reg.kind] - 1'b1;
                                end
                                if ((!pvalid || kmatch) && !free_reg) begin
                                    free_reg     <= 1'b1;
                                    free_idx_reg <= pi_reg;
                                end
                            end
                            default: begin
                                if (pvalid && rd_reg.src == src_reg) begin
                                    valid_reg[pi_reg]     <= 1'b0;
                                    bytes_reg             <= rd_sub;
                                    kcnt_reg[rd_reg.kind] <= kcnt_reg[rd_reg.kind] - 1'b1;
                                    removed_reg           <= removed_reg + 1'b1;
                                    invc_reg              <= invc_reg + 1'b1;
                                end
                            end
                        endcase
                    end else if (!issuing) begin
                        // scan finished
                        cnt_reg <= '0;
                        case (op_reg)
                            bbltd_pkg::OP_LOOKUP: begin
                                if (found_reg && found_rec_reg.kind == kind_reg) begin
                                    state_reg <= S_WRITE;
                                end else begin
                                    miss_reg[kind_reg] <= miss_reg[kind_reg] + 1'b1;
                                    status_reg <= bbltd_pkg::ST_MISS;
                                    state_reg  <= S_DONE;
                                end
                            end
                            bbltd_pkg::OP_STORE: begin
                                if (free_reg) begin
                                    state_reg <= S_WRITE;
                                end else begin
                                    store_full_reg <= 1'b1;
                                    have_reg       <= 1'b0;
                                    state_reg      <= S_LRU;
                                end
                            end
                            default: begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_LRU: begin
                    cnt_reg <= issuing ? cnt_reg + 1'b1 : cnt_reg;
                    pv_reg  <= issuing;
                    pi_reg  <= cnt_reg[IW-1:0];
                    if (pv_reg) begin
                        if (pvalid && better) begin
                            have_reg     <= 1'b1;
                            best_idx_reg <= pi_reg;
                            best_reg     <= rd_reg;
                        end
                    end else if (!issuing) begin
                        cnt_reg <= '0;
                        if (have_reg) begin
                            // drop the victim
                            valid_reg[best_idx_reg] <= 1'b0;
                            bytes_reg               <= best_sub;
                            kcnt_reg[best_reg.kind] <= kcnt_reg[best_reg.kind] - 1'b1;
                            evicted_reg             <= evicted_reg + 1'b1;
                            evc_reg                 <= evc_reg + 1'b1;
                            if (store_full_reg) begin
                                store_full_reg <= 1'b0;
                                free_idx_reg   <= best_idx_reg;
                                state_reg      <= S_WRITE;
                            end else begin
                                state_reg <= S_FIT;
                            end
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_WRITE: begin
                    serial_reg <= serial_next;
                    if (op_reg == bbltd_pkg::OP_LOOKUP) begin
                        hit_reg[kind_reg] <= hit_reg[kind_reg] + 1'b1;
                        slot_reg  <= found_idx_reg;
                        state_reg <= S_DONE;
                    end else begin
                        valid_reg[free_idx_reg] <= 1'b1;
                        bytes_reg          <= bytes_reg + BW'(size_reg);
                        kcnt_reg[kind_reg] <= kcnt_reg[kind_reg] + 1'b1;
                        slot_reg  <= free_idx_reg;
                        state_reg <= S_FIT;
                    end
                end
                S_FIT: begin
                    if (bytes_w > budget_w) begin
                        have_reg  <= 1'b0;
                        cnt_reg   <= '0;
                        pv_reg    <= 1'b0;
                        state_reg <= S_LRU;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    m_tdata_reg <= {2'b00, invc_reg, evc_reg, miss_reg[kind_reg],
                                    hit_reg[kind_reg], 9'(kcnt_reg[1]), 9'(kcnt_reg[0]),
                                    40'(bytes_reg), removed_reg, evicted_reg,
                                    8'(slot_reg), status_reg};
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== design/bbltd_checker.sv =====
// Port-level checks for the tile directory, bound to the top level.
module bbltd_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready
);
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready right after an accepted item");

    a_result_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> !m_tvalid)
        else $error("result repeated");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped before taken");
endmodule

bind byte_budget_lru_tile_directory_unit bbltd_checker u_bbltd_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready)
);
